>>> rtl/lbbc_pkg.sv
// ----------------------------------------------------------------------------
// lbbc_pkg
// Shared types and constants of the block buffer cache: slot geometry,
// operation and status codes, sequencer states and slot store ports.
// ----------------------------------------------------------------------------
package lbbc_pkg;

	localparam int SLOT_COUNT = 32;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = SLOT_W + 1;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	typedef enum logic [1:0] {
		OP_GET     = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_UNDER  = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic [SLOT_W-1:0] addr;
		logic              tag_en;
		logic [7:0]        dev;
		logic [31:0]       blk;
		logic              cnt_en;
		logic [7:0]        cnt;
		logic              cv_en;
		logic              stamp_en;
		logic [31:0]       stamp;
	} store_wr_t;

	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [7:0]  cnt;
		logic        cv;
		logic [31:0] stamp;
	} store_rd_t;

endpackage

>>> rtl/lbbc_in_if.sv
// ----------------------------------------------------------------------------
// lbbc_in_if
// Request channel of the block buffer cache: valid/ready and the request.
// ----------------------------------------------------------------------------
interface lbbc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  device_id;
	logic [31:0] block_number;
	logic [4:0]  buffer_slot;
	logic [31:0] now_time;

	modport source (
		output valid, operation, device_id, block_number, buffer_slot, now_time,
		input  ready
	);
	modport sink (
		input  valid, operation, device_id, block_number, buffer_slot, now_time,
		output ready
	);
endinterface

>>> rtl/lbbc_out_if.sv
// ----------------------------------------------------------------------------
// lbbc_out_if
// Result channel of the block buffer cache: valid/ready and the result.
// ----------------------------------------------------------------------------
interface lbbc_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] slot_index;
	logic       was_hit;
	logic       needs_read;
	logic [7:0] ref_after;
	logic [1:0] status;

	modport source (
		output valid, slot_index, was_hit, needs_read, ref_after, status,
		input  ready
	);
	modport sink (
		input  valid, slot_index, was_hit, needs_read, ref_after, status,
		output ready
	);
endinterface

>>> rtl/lbbc_slot_store.sv
// ----------------------------------------------------------------------------
// lbbc_slot_store
// Per-slot state: tag and stamp memories with written bits, reference
// counts and contents-valid bits; one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module lbbc_slot_store (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [lbbc_pkg::SLOT_W-1:0]      rd_addr,
	output lbbc_pkg::store_rd_t              rd_data,
	input  lbbc_pkg::store_wr_t              wr
);

	logic [39:0] tag_mem   [lbbc_pkg::SLOT_COUNT];
	logic [31:0] stamp_mem [lbbc_pkg::SLOT_COUNT];

	logic [lbbc_pkg::SLOT_COUNT-1:0] tag_wr_q;
	logic [lbbc_pkg::SLOT_COUNT-1:0] stamp_wr_q;
	logic [lbbc_pkg::SLOT_COUNT-1:0] cv_q;
	logic [7:0]                      cnt_q [lbbc_pkg::SLOT_COUNT];

	logic [39:0] tag_rd_q;
	logic [31:0] stamp_rd_q;
	logic        tag_ok_q;
	logic        stamp_ok_q;
	logic [7:0]  cnt_rd_q;
	logic        cv_rd_q;

	// memories
	always_ff @(posedge clk) begin
		if (wr.tag_en) begin
			tag_mem[wr.addr] <= {wr.dev, wr.blk};
		end
		if (wr.stamp_en) begin
			stamp_mem[wr.addr] <= wr.stamp;
		end
		if (rd_en) begin
			tag_rd_q   <= tag_mem[rd_addr];
			stamp_rd_q <= stamp_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_wr_q   <= '0;
			stamp_wr_q <= '0;
			cv_q       <= '0;
			for (int i = 0; i < lbbc_pkg::SLOT_COUNT; i++) begin
				cnt_q[i] <= '0;
			end
			tag_ok_q   <= 1'b0;
			stamp_ok_q <= 1'b0;
			cnt_rd_q   <= '0;
			cv_rd_q    <= 1'b0;
		end else begin
			if (wr.tag_en) begin
				tag_wr_q[wr.addr] <= 1'b1;
			end
			if (wr.stamp_en) begin
				stamp_wr_q[wr.addr] <= 1'b1;
			end
			if (wr.cv_en) begin
				cv_q[wr.addr] <= 1'b1;
			end
			if (wr.cnt_en) begin
				cnt_q[wr.addr] <= wr.cnt;
			end
			if (rd_en) begin
				tag_ok_q   <= tag_wr_q[rd_addr];
				stamp_ok_q <= stamp_wr_q[rd_addr];
				cnt_rd_q   <= cnt_q[rd_addr];
				cv_rd_q    <= cv_q[rd_addr];
			end
		end
	end

	// unwritten entries read as zero
	always_comb begin
		rd_data.dev   = tag_ok_q ? tag_rd_q[39:32] : 8'd0;
		rd_data.blk   = tag_ok_q ? tag_rd_q[31:0] : 32'd0;
		rd_data.stamp = stamp_ok_q ? stamp_rd_q : 32'd0;
		rd_data.cnt   = cnt_rd_q;
		rd_data.cv    = cv_rd_q;
	end

endmodule

>>> rtl/lru_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit
// Buffer cache of tagged slots with reference counts and LRU reclaim.
// ----------------------------------------------------------------------------
// usage:
//   req (sink) takes one request: operation, device_id, block_number,
//   buffer_slot, now_time. rsp (source) gives one result per request:
//   slot_index, was_hit, needs_read, ref_after, status.
//   a get walks every slot once through a single registered read port and
//   one tag/stamp compare; release, pin and unpin read one slot. req.ready
//   is high only while no request is in work, so a new request is taken
//   only once the last one is done; ready rises as its result is registered.
//   the result sits in an output register; a new request may be taken while
//   it waits, but that request's result is held back, with no state change,
//   until rsp.ready has taken the earlier one.
//   after reset all slots are tagged device 0 block 0, with zero counts,
//   zero stamps and contents invalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit (
	input  logic        clk,
	input  logic        arst_n,
	lbbc_in_if.sink     req,
	lbbc_out_if.source  rsp
);

	lbbc_pkg::state_t state_q, state_d;

	logic [1:0]  op_q;
	logic [7:0]  dev_q;
	logic [31:0] blk_q;
	logic [4:0]  slot_q;
	logic [31:0] now_q;

	logic [lbbc_pkg::CNT_W-1:0]  addr_q;
	logic                        pend_s1;
	logic [lbbc_pkg::SLOT_W-1:0] idx_s1;

	logic                        hit_q;
	logic [lbbc_pkg::SLOT_W-1:0] hit_idx_q;
	logic [7:0]                  hit_cnt_q;
	logic                        hit_cv_q;
	logic                        vic_q;
	logic [lbbc_pkg::SLOT_W-1:0] vic_idx_q;
	logic [31:0]                 best_q;

	logic                        rd_en;
	logic [lbbc_pkg::SLOT_W-1:0] rd_addr;
	lbbc_pkg::store_rd_t         rd_data;
	lbbc_pkg::store_wr_t         wr;

	logic       accept;
	logic       commit;
	logic       scan_end;
	logic       tag_match;
	logic       vic_take;
	logic       in_range;
	logic [4:0] res_slot;
	logic       res_hit;
	logic       res_read;
	logic [7:0] res_cnt;
	logic [1:0] res_st;

	logic       out_vld_q;
	logic [4:0] out_slot_q;
	logic       out_hit_q;
	logic       out_read_q;
	logic [7:0] out_cnt_q;
	logic [1:0] out_st_q;

	lbbc_slot_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	assign req.ready = (state_q == lbbc_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign scan_end  = (addr_q == lbbc_pkg::CNT_W'(lbbc_pkg::SLOT_COUNT)) && !pend_s1;
	assign in_range  = ({27'd0, slot_q} < 32'(lbbc_pkg::SLOT_COUNT));

	// shared compare on the slot read back this cycle
	assign tag_match = pend_s1 && !hit_q && (rd_data.dev == dev_q) && (rd_data.blk == blk_q);
	assign vic_take  = pend_s1 && (rd_data.cnt == 8'd0) && (!vic_q || (rd_data.stamp <= best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbbc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = addr_q[lbbc_pkg::SLOT_W-1:0];
		commit   = 1'b0;
		wr       = '0;
		wr.addr  = lbbc_pkg::SLOT_W'(slot_q);
		wr.stamp = now_q;
		wr.dev   = dev_q;
		wr.blk   = blk_q;
		res_slot = slot_q;
		res_hit  = 1'b0;
		res_read = 1'b0;
		res_cnt  = 8'd0;
		res_st   = lbbc_pkg::ST_OK;
		unique case (state_q)
			lbbc_pkg::S_IDLE: begin
				if (accept) begin
					if (req.operation == lbbc_pkg::OP_GET) begin
						state_d = lbbc_pkg::S_SCAN;
					end else begin
						state_d = lbbc_pkg::S_READ;
					end
				end
			end
			lbbc_pkg::S_READ: begin
				rd_en   = 1'b1;
				rd_addr = lbbc_pkg::SLOT_W'(slot_q);
				state_d = lbbc_pkg::S_APPLY;
			end
			lbbc_pkg::S_SCAN: begin
				rd_en = (addr_q < lbbc_pkg::CNT_W'(lbbc_pkg::SLOT_COUNT));
				if (scan_end) begin
					state_d = lbbc_pkg::S_APPLY;
				end
			end
			lbbc_pkg::S_APPLY: begin
				commit = !out_vld_q || rsp.ready;
				if (op_q == lbbc_pkg::OP_GET) begin
					if (hit_q) begin
						wr.addr  = hit_idx_q;
						wr.cv_en = 1'b1;
						res_slot = 5'(hit_idx_q);
						res_hit  = 1'b1;
						res_read = !hit_cv_q;
						if (hit_cnt_q == lbbc_pkg::COUNT_MAX) begin
							res_cnt = hit_cnt_q;
							res_st  = lbbc_pkg::ST_SAT;
						end else begin
							res_cnt   = hit_cnt_q + 8'd1;
							wr.cnt_en = 1'b1;
						end
					end else if (vic_q) begin
						wr.addr   = vic_idx_q;
						wr.tag_en = 1'b1;
						wr.cnt_en = 1'b1;
						wr.cv_en  = 1'b1;
						res_slot  = 5'(vic_idx_q);
						res_read  = 1'b1;
						res_cnt   = 8'd1;
					end else begin
						res_slot = 5'd0;
						res_st   = lbbc_pkg::ST_NOFREE;
					end
				end else if (in_range) begin
					if (op_q == lbbc_pkg::OP_PIN) begin
						if (rd_data.cnt == lbbc_pkg::COUNT_MAX) begin
							res_cnt = rd_data.cnt;
							res_st  = lbbc_pkg::ST_SAT;
						end else begin
							res_cnt   = rd_data.cnt + 8'd1;
							wr.cnt_en = 1'b1;
						end
					end else if (rd_data.cnt == 8'd0) begin
						res_st = lbbc_pkg::ST_UNDER;
					end else begin
						res_cnt     = rd_data.cnt - 8'd1;
						wr.cnt_en   = 1'b1;
						wr.stamp_en = (op_q == lbbc_pkg::OP_RELEASE) && (res_cnt == 8'd0);
					end
				end
				wr.cnt = res_cnt;
				if (!commit) begin
					wr.tag_en   = 1'b0;
					wr.cnt_en   = 1'b0;
					wr.cv_en    = 1'b0;
					wr.stamp_en = 1'b0;
				end else begin
					state_d = lbbc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lbbc_pkg::S_IDLE;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			dev_q  <= req.device_id;
			blk_q  <= req.block_number;
			slot_q <= req.buffer_slot;
			now_q  <= req.now_time;
		end
	end

	// scan sequencer and running hit / victim choice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			pend_s1   <= 1'b0;
			idx_s1    <= '0;
			hit_q     <= 1'b0;
			vic_q     <= 1'b0;
			hit_idx_q <= '0;
			hit_cnt_q <= '0;
			hit_cv_q  <= 1'b0;
			vic_idx_q <= '0;
			best_q    <= '0;
		end else if (accept) begin
			addr_q  <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
			vic_q   <= 1'b0;
		end else if (state_q == lbbc_pkg::S_SCAN) begin
			pend_s1 <= rd_en;
			idx_s1  <= addr_q[lbbc_pkg::SLOT_W-1:0];
			if (rd_en) begin
				addr_q <= addr_q + lbbc_pkg::CNT_W'(1);
			end
			if (tag_match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_cnt_q <= rd_data.cnt;
				hit_cv_q  <= rd_data.cv;
			end
			if (vic_take) begin
				vic_q     <= 1'b1;
				vic_idx_q <= idx_s1;
				best_q    <= rd_data.stamp;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_slot_q <= res_slot;
			out_hit_q  <= res_hit;
			out_read_q <= res_read;
			out_cnt_q  <= res_cnt;
			out_st_q   <= res_st;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.slot_index = out_slot_q;
	assign rsp.was_hit    = out_hit_q;
	assign rsp.needs_read = out_read_q;
	assign rsp.ref_after  = out_cnt_q;
	assign rsp.status     = out_st_q;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU block buffer cache. A queue of requests is
// driven over the valid/ready request channel; every accepted request is run
// through a shadow copy of the slot table to predict its result, and the
// result channel is compared field by field in order. Directed requests
// cover reset tags, reclaim ties, underflow and the all-ones corners. Random
// traffic mixes hits, misses, releases, pins and unpins, a fill to exhaustion
// and a pin burst to saturation, with idling on both sides and two long
// back-pressure hold-offs on the result side.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STALL_LIMIT = 4000;
	localparam int BATCH       = 16;

	typedef struct packed {
		lbbc_pkg::op_t op;
		logic [7:0]    dev;
		logic [31:0]   blk;
		logic [4:0]    slot;
		logic [31:0]   now;
	} cache_req_t;

	typedef struct packed {
		logic [4:0]        slot;
		logic              hit;
		logic              rd;
		logic [7:0]        cnt;
		lbbc_pkg::status_t st;
	} cache_rsp_t;

	logic clk;
	logic arst_n;

	lbbc_in_if  req_if ();
	lbbc_out_if rsp_if ();

	lru_block_buffer_cache_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow slot table
	logic [7:0]  sh_dev   [lbbc_pkg::SLOT_COUNT];
	logic [31:0] sh_blk   [lbbc_pkg::SLOT_COUNT];
	logic [7:0]  sh_cnt   [lbbc_pkg::SLOT_COUNT];
	logic [31:0] sh_stamp [lbbc_pkg::SLOT_COUNT];
	logic        sh_valid [lbbc_pkg::SLOT_COUNT];

	cache_req_t req_pending [$];
	cache_rsp_t rsp_expected [$];
	cache_req_t req_cur;
	cache_rsp_t rsp_exp;

	int          n_pushed;
	int          n_taken = 0;
	int          n_results = 0;
	int          n_errors = 0;
	int          n_hits = 0;
	int          n_misses = 0;
	int          n_nofree = 0;
	int          n_under = 0;
	int          n_sat = 0;
	int          hold_left;
	int          holds_done = 0;
	int          stall_cycles = 0;
	int unsigned cyc = 0;
	logic [31:0] tick;

	always #5 clk = ~clk;

	function automatic cache_rsp_t cache_apply(cache_req_t r);
		cache_rsp_t res;
		bit found;
		int idx;
		logic [31:0] best;
		res.slot = r.slot;
		res.hit  = 1'b0;
		res.rd   = 1'b0;
		res.cnt  = '0;
		res.st   = lbbc_pkg::ST_OK;
		found    = 1'b0;
		idx      = 0;
		best     = '0;
		if (r.op == lbbc_pkg::OP_GET) begin
			for (int i = 0; i < lbbc_pkg::SLOT_COUNT; i++) begin
				if (!found && sh_dev[i] == r.dev && sh_blk[i] == r.blk) begin
					found = 1'b1;
					idx   = i;
				end
			end
			if (found) begin
				if (sh_cnt[idx] >= lbbc_pkg::COUNT_MAX) begin
					res.st = lbbc_pkg::ST_SAT;
				end else begin
					sh_cnt[idx] = sh_cnt[idx] + 8'd1;
				end
				res.slot      = 5'(idx);
				res.hit       = 1'b1;
				res.rd        = !sh_valid[idx];
				res.cnt       = sh_cnt[idx];
				sh_valid[idx] = 1'b1;
			end else begin
				for (int i = 0; i < lbbc_pkg::SLOT_COUNT; i++) begin
					if (sh_cnt[i] == 8'd0 && (!found || sh_stamp[i] <= best)) begin
						found = 1'b1;
						best  = sh_stamp[i];
						idx   = i;
					end
				end
				if (!found) begin
					res.slot = '0;
					res.st   = lbbc_pkg::ST_NOFREE;
				end else begin
					sh_dev[idx]   = r.dev;
					sh_blk[idx]   = r.blk;
					sh_cnt[idx]   = 8'd1;
					sh_valid[idx] = 1'b1;
					res.slot      = 5'(idx);
					res.rd        = 1'b1;
					res.cnt       = 8'd1;
				end
			end
		end else if (int'(r.slot) < lbbc_pkg::SLOT_COUNT) begin
			idx = int'(r.slot);
			if (r.op == lbbc_pkg::OP_PIN) begin
				if (sh_cnt[idx] >= lbbc_pkg::COUNT_MAX) begin
					res.st = lbbc_pkg::ST_SAT;
				end else begin
					sh_cnt[idx] = sh_cnt[idx] + 8'd1;
				end
			end else if (sh_cnt[idx] == 8'd0) begin
				res.st = lbbc_pkg::ST_UNDER;
			end else begin
				sh_cnt[idx] = sh_cnt[idx] - 8'd1;
				if (r.op == lbbc_pkg::OP_RELEASE && sh_cnt[idx] == 8'd0) begin
					sh_stamp[idx] = r.now;
				end
			end
			res.cnt = sh_cnt[idx];
		end
		return res;
	endfunction

	function automatic logic [31:0] next_now();
		if ($urandom_range(0, 9) == 0) begin
			tick = $urandom;
		end else begin
			tick = tick + 32'($urandom_range(0, 3));
		end
		return tick;
	endfunction

	// mostly a slot that is held, now and then any slot
	function automatic logic [4:0] pick_slot();
		int base;
		base = $urandom_range(0, lbbc_pkg::SLOT_COUNT - 1);
		if ($urandom_range(0, 9) < 7) begin
			for (int j = 0; j < lbbc_pkg::SLOT_COUNT; j++) begin
				if (sh_cnt[(base + j) % lbbc_pkg::SLOT_COUNT] != 8'd0) begin
					return 5'((base + j) % lbbc_pkg::SLOT_COUNT);
				end
			end
		end
		return 5'(base);
	endfunction

	task automatic push_req(lbbc_pkg::op_t op, logic [7:0] dev, logic [31:0] blk,
			logic [4:0] slot, logic [31:0] now);
		cache_req_t r;
		r.op   = op;
		r.dev  = dev;
		r.blk  = blk;
		r.slot = slot;
		r.now  = now;
		req_pending.push_back(r);
		n_pushed++;
	endtask

	task automatic wait_drained();
		while (n_taken != n_pushed || rsp_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic gen_mixed(int count);
		int roll;
		int s;
		logic [7:0] dev;
		logic [31:0] blk;
		for (int k = 0; k < count; k++) begin
			if (k % BATCH == 0) begin
				wait_drained();
			end
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				s = $urandom_range(0, lbbc_pkg::SLOT_COUNT - 1);
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					dev = sh_dev[s];
					blk = sh_blk[s];
				end else if (roll < 60) begin
					dev = 8'h00;
					blk = 32'h0;
				end else if (roll < 65) begin
					dev = 8'hFF;
					blk = 32'hFFFF_FFFF;
				end else begin
					dev = 8'($urandom_range(0, 255));
					blk = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 15));
				end
				push_req(lbbc_pkg::OP_GET, dev, blk, 5'($urandom), next_now());
			end else if (roll < 70) begin
				push_req(lbbc_pkg::OP_RELEASE, 8'($urandom), $urandom, pick_slot(),
					next_now());
			end else if (roll < 80) begin
				push_req(lbbc_pkg::OP_PIN, 8'($urandom), $urandom, pick_slot(), next_now());
			end else begin
				push_req(lbbc_pkg::OP_UNPIN, 8'($urandom), $urandom, pick_slot(),
					next_now());
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				rsp_expected.push_back(cache_apply(req_cur));
				n_taken++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (req_pending.size() != 0
						&& !($urandom_range(0, 99) < 8 && !(cyc >= 4000 && cyc < 9000))) begin
					req_cur = req_pending.pop_front();
					req_if.valid        <= 1'b1;
					req_if.operation    <= req_cur.op;
					req_if.device_id    <= req_cur.dev;
					req_if.block_number <= req_cur.blk;
					req_if.buffer_slot  <= req_cur.slot;
					req_if.now_time     <= req_cur.now;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and result-side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_left    <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				n_results++;
				if (rsp_expected.size() == 0) begin
					$error("result with no request outstanding: slot_index %0d",
						rsp_if.slot_index);
					n_errors++;
				end else begin
					rsp_exp = rsp_expected.pop_front();
					if (rsp_exp.st == lbbc_pkg::ST_NOFREE) n_nofree++;
					else if (rsp_exp.st == lbbc_pkg::ST_UNDER) n_under++;
					else if (rsp_exp.st == lbbc_pkg::ST_SAT) n_sat++;
					if (rsp_exp.hit) n_hits++;
					else if (rsp_exp.rd) n_misses++;
					if (rsp_if.slot_index !== rsp_exp.slot) begin
						$error("slot_index: expected %0d, actual %0d",
							rsp_exp.slot, rsp_if.slot_index);
						n_errors++;
					end
					if (rsp_if.was_hit !== rsp_exp.hit) begin
						$error("was_hit: expected %0d, actual %0d",
							rsp_exp.hit, rsp_if.was_hit);
						n_errors++;
					end
					if (rsp_if.needs_read !== rsp_exp.rd) begin
						$error("needs_read: expected %0d, actual %0d",
							rsp_exp.rd, rsp_if.needs_read);
						n_errors++;
					end
					if (rsp_if.ref_after !== rsp_exp.cnt) begin
						$error("ref_after: expected %0d, actual %0d",
							rsp_exp.cnt, rsp_if.ref_after);
						n_errors++;
					end
					if (rsp_if.status !== rsp_exp.st) begin
						$error("status: expected %0d, actual %0d",
							rsp_exp.st, rsp_if.status);
						n_errors++;
					end
				end
			end
			if (hold_left != 0) begin
				rsp_if.ready <= 1'b0;
				hold_left    <= hold_left - 1;
			end else if ((holds_done == 0 && n_results >= 120)
					|| (holds_done == 1 && n_results >= 450)) begin
				holds_done++;
				rsp_if.ready <= 1'b0;
				hold_left    <= 300;
			end else begin
				rsp_if.ready <= !($urandom_range(0, 99) < 8 && !(cyc >= 4000 && cyc < 9000));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
				$display("lru_block_buffer_cache_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int s;
		int need;
		clk      = 1'b0;
		arst_n   = 1'b0;
		n_pushed = 0;
		tick     = '0;
		for (int i = 0; i < lbbc_pkg::SLOT_COUNT; i++) begin
			sh_dev[i]   = '0;
			sh_blk[i]   = '0;
			sh_cnt[i]   = '0;
			sh_stamp[i] = '0;
			sh_valid[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset tags hit slot 0, then reclaim ties, underflow and all-ones corners
		push_req(lbbc_pkg::OP_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0000_0000);
		push_req(lbbc_pkg::OP_GET,     8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
		push_req(lbbc_pkg::OP_GET,     8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0000_0000);
		push_req(lbbc_pkg::OP_GET,     8'h80, 32'h8000_0000, 5'd16, 32'h0000_0001);
		push_req(lbbc_pkg::OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
		push_req(lbbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 32'h0000_0002);
		push_req(lbbc_pkg::OP_UNPIN,   8'h00, 32'h0000_0000, 5'd31, 32'h0000_0003);
		push_req(lbbc_pkg::OP_PIN,     8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
		push_req(lbbc_pkg::OP_UNPIN,   8'h00, 32'h0000_0000, 5'd31, 32'h0000_0004);
		push_req(lbbc_pkg::OP_GET,     8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
		push_req(lbbc_pkg::OP_RELEASE, 8'h55, 32'h5555_5555, 5'd30, 32'h0000_0000);
		push_req(lbbc_pkg::OP_GET,     8'h01, 32'h0000_0005, 5'd0,  32'h0000_0000);
		push_req(lbbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'h0000_0007);
		push_req(lbbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'h0000_0007);
		push_req(lbbc_pkg::OP_UNPIN,   8'hAA, 32'hAAAA_AAAA, 5'd0,  32'h0000_0008);
		push_req(lbbc_pkg::OP_GET,     8'h00, 32'h0000_0000, 5'd1,  32'h0000_0009);
		push_req(lbbc_pkg::OP_PIN,     8'h00, 32'h0000_0000, 5'd0,  32'h0000_000A);
		push_req(lbbc_pkg::OP_GET,     8'h00, 32'h0000_0001, 5'd2,  32'h0000_000B);
		push_req(lbbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 32'h0000_0005);
		push_req(lbbc_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd29, 32'h0000_0003);
		push_req(lbbc_pkg::OP_GET,     8'h02, 32'h0000_0002, 5'd3,  32'h0000_000C);
		push_req(lbbc_pkg::OP_GET,     8'hFF, 32'hFFFF_FFFF, 5'd4,  32'h0000_000D);

		gen_mixed(70);

		// claim every slot, then miss with nothing free
		wait_drained();
		for (int k = 0; k < lbbc_pkg::SLOT_COUNT + 4; k++) begin
			push_req(lbbc_pkg::OP_GET, 8'($urandom_range(0, 255)), $urandom, 5'($urandom),
				next_now());
		end
		wait_drained();
		for (int i = 0; i < lbbc_pkg::SLOT_COUNT; i++) begin
			if (sh_cnt[i] <= 8'd8) begin
				for (int k = 0; k < int'(sh_cnt[i]); k++) begin
					push_req(lbbc_pkg::OP_RELEASE, 8'($urandom), $urandom, 5'(i), next_now());
				end
			end
		end

		gen_mixed(50);

		// pin one slot up to saturation, then hit it with a get
		wait_drained();
		s    = $urandom_range(0, lbbc_pkg::SLOT_COUNT - 1);
		need = 256 - int'(sh_cnt[s]);
		for (int k = 0; k < need; k++) begin
			push_req(lbbc_pkg::OP_PIN, 8'($urandom), $urandom, 5'(s), next_now());
		end
		push_req(lbbc_pkg::OP_GET, sh_dev[s], sh_blk[s], 5'($urandom), next_now());
		push_req(lbbc_pkg::OP_UNPIN, 8'($urandom), $urandom, 5'(s), next_now());
		push_req(lbbc_pkg::OP_RELEASE, 8'($urandom), $urandom, 5'(s), next_now());

		gen_mixed(70);

		wait_drained();
		repeat (50) @(posedge clk);
		$display("ran %0d requests: %0d get hits, %0d get misses, %0d no-free-buffer",
			n_taken, n_hits, n_misses, n_nofree);
		$display("%0d count underflows, %0d saturations, %0d back-pressure hold-offs",
			n_under, n_sat, holds_done);
		if (n_errors == 0 && rsp_expected.size() == 0) begin
			$display("lru_block_buffer_cache_unit: match");
		end else begin
			$display("lru_block_buffer_cache_unit: mismatch");
		end
		$finish;
	end

endmodule
